>>> design/crc32_reflected_byte_stream_top_assert.svh
// assertion macros for the crc32 byte stream block
`ifndef CRC32_REFLECTED_BYTE_STREAM_TOP_ASSERT_SVH
`define CRC32_REFLECTED_BYTE_STREAM_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// implication checked outside reset
`define CRC32_ASSERT_IMP(label, lhs, rhs) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |-> (rhs)) \
      else $error("crc32 assertion failed");

// next-cycle implication checked outside reset
`define CRC32_ASSERT_NXT(label, lhs, rhs) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |=> (rhs)) \
      else $error("crc32 assertion failed");

// condition that must hold in the cycle after reset
`define CRC32_ASSERT_RST(label, rhs) \
   label: assert property (@(posedge clock) reset |=> (rhs)) \
      else $error("crc32 assertion failed");

`else

`define CRC32_ASSERT_IMP(label, lhs, rhs)
`define CRC32_ASSERT_NXT(label, lhs, rhs)
`define CRC32_ASSERT_RST(label, rhs)

`endif

`endif

>>> design/crc32_pkg.sv
// package with types, constants and the byte update function of the crc32 block
`timescale 1ns / 1ps

package crc32_pkg;

   localparam int DATA_W = 8;
   localparam int CRC_W  = 32;

   localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;

   typedef logic [DATA_W-1:0] data_byte_type;
   typedef logic [CRC_W-1:0]  crc_type;

   // one data byte folded into the reflected remainder
   function automatic crc_type crc_next(crc_type rem, data_byte_type data);
      crc_type v;
      int      k;
      v = {{(CRC_W-DATA_W){1'b0}}, rem[DATA_W-1:0] ^ data};
      for (k = 0; k < DATA_W; k++) begin
         if (v[0]) begin
            v = (v >> 1) ^ CRC_POLY;
         end else begin
            v = v >> 1;
         end
      end
      return (rem >> DATA_W) ^ v;
   endfunction

endpackage

>>> design/crc32_req_if.sv
// request channel interface carrying one data byte and its framing marks
`timescale 1ns / 1ps

interface crc32_req_if;
   import crc32_pkg::*;

   logic          valid;
   logic          ready;
   data_byte_type data_byte;
   logic          first_byte;
   logic          last_byte;

   modport source (output valid, output data_byte, output first_byte, output last_byte,
                   input ready);
   modport sink   (input valid, input data_byte, input first_byte, input last_byte,
                   output ready);
endinterface

>>> design/crc32_rsp_if.sv
// response channel interface carrying the running crc and the final mark
`timescale 1ns / 1ps

interface crc32_rsp_if;
   import crc32_pkg::*;

   logic    valid;
   logic    ready;
   crc_type crc_value;
   logic    is_final;

   modport source (output valid, output crc_value, output is_final, input ready);
   modport sink   (input valid, input crc_value, input is_final, output ready);
endinterface

>>> design/crc32_reflected_byte_stream_top.sv
`timescale 1ns / 1ps
// Byte-wise reflected CRC-32 (polynomial 0xEDB88320, start value zero, no
// final inversion). Each request transfer carries one byte; first_byte clears
// the running remainder before the byte is folded in, last_byte is echoed as
// is_final. Every request gives exactly one response with the remainder after
// that byte. One byte is taken every cycle while the response side keeps up:
// a request lands in an input register, the eight-step XOR network folds it
// into the remainder, and the remainder and the result register are loaded
// together as the input register advances; a stalled response side holds the
// result register, which back-pressures the request side. Response valid is driven from the result register.

module crc32_reflected_byte_stream_top (
   input logic        clock,
   input logic        reset,
   crc32_req_if.sink   req_ch,
   crc32_rsp_if.source rsp_ch
);
   import crc32_pkg::*;

   logic          s1_valid_ff, s1_valid_in;
   data_byte_type s1_data_ff;
   logic          s1_first_ff;
   logic          s1_last_ff;

   logic          out_valid_ff, out_valid_in;
   crc_type       out_crc_ff;
   logic          out_final_ff;

   crc_type       remainder_ff;
   crc_type       crc_base;
   crc_type       crc_result;

   logic          s1_adv;
   logic          req_xfer;

   assign s1_adv   = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_xfer = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !s1_valid_ff || s1_adv;

   // first byte starts from a cleared remainder
   assign crc_base   = s1_first_ff ? '0 : remainder_ff;
   assign crc_result = crc_next(crc_base, s1_data_ff);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (s1_adv) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         remainder_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (s1_adv) begin
            remainder_ff <= crc_result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_data_ff  <= req_ch.data_byte;
         s1_first_ff <= req_ch.first_byte;
         s1_last_ff  <= req_ch.last_byte;
      end
      if (s1_adv) begin
         out_crc_ff   <= crc_result;
         out_final_ff <= s1_last_ff;
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.crc_value = out_crc_ff;
   assign rsp_ch.is_final  = out_final_ff;

`include "crc32_reflected_byte_stream_top_assert.svh"

   `CRC32_ASSERT_RST(a_reset_empty, !s1_valid_ff && !out_valid_ff && remainder_ff == '0)
   `CRC32_ASSERT_NXT(a_adv_fills_out, s1_adv, out_valid_ff)
   `CRC32_ASSERT_IMP(a_out_matches_rem, out_valid_ff, out_crc_ff == remainder_ff)
   `CRC32_ASSERT_NXT(a_first_restarts, s1_adv && s1_first_ff,
                     out_crc_ff == crc_next('0, $past(s1_data_ff)))

endmodule

>>> tb/sv/crc32_stream_checker.sv
// watches both channels of the crc32 byte stream block and compares each response
`timescale 1ns / 1ps

module crc32_stream_checker (
   input  logic  clock,
   input  logic  reset,
   crc32_req_if  req_mon,
   crc32_rsp_if  rsp_mon,
   output int    mismatch_count,
   output int    outstanding
);
   import crc32_pkg::*;

   typedef struct packed {
      crc_type crc_value;
      logic    is_final;
   } crc_result_type;

   crc_result_type expected_crcs[$];
   crc_type        running_crc;

   // serial form: one message bit per step, lsb first
   function automatic crc_type fold_byte(crc_type rem, data_byte_type data);
      crc_type r;
      logic    feedback;
      int      i;
      r = rem;
      for (i = 0; i < DATA_W; i++) begin
         feedback = r[0] ^ data[i];
         r = {1'b0, r[CRC_W-1:1]};
         if (feedback) begin
            r = r ^ CRC_POLY;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      crc_result_type want;
      if (reset) begin
         running_crc = '0;
         expected_crcs.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_crcs.size() == 0) begin
               $display("%0t: unexpected response crc_value=%h is_final=%b", $time,
                        rsp_mon.crc_value, rsp_mon.is_final);
               mismatch_count = mismatch_count + 1;
            end else begin
               want = expected_crcs.pop_front();
               if (rsp_mon.crc_value !== want.crc_value) begin
                  $display("%0t: crc_value mismatch expected=%h actual=%h", $time,
                           want.crc_value, rsp_mon.crc_value);
                  mismatch_count = mismatch_count + 1;
               end
               if (rsp_mon.is_final !== want.is_final) begin
                  $display("%0t: is_final mismatch expected=%b actual=%b", $time,
                           want.is_final, rsp_mon.is_final);
                  mismatch_count = mismatch_count + 1;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.first_byte) begin
               running_crc = '0;
            end
            running_crc = fold_byte(running_crc, req_mon.data_byte);
            expected_crcs.push_back(crc_result_type'{running_crc, req_mon.last_byte});
         end
      end
      outstanding = expected_crcs.size();
   end

endmodule

>>> tb/sv/crc32_reflected_byte_stream_top_tb.sv
// testbench top for the crc32 byte stream block: stimulus, flow control and verdict
`timescale 1ns / 1ps

module crc32_reflected_byte_stream_top_tb;
   import crc32_pkg::*;

   localparam int RESET_CYCLES = 12;
   localparam int HOLD_CYCLES  = 200;
   localparam int PHASE_BYTES  = 320;
   localparam int DRAIN_CYCLES = 8;

   logic clock = 1'b0;
   logic reset;
   int   send_idle_pct;
   int   recv_stall_pct;
   bit   long_hold;
   int   mismatch_count;
   int   outstanding;

   crc32_req_if req_bus ();
   crc32_rsp_if rsp_bus ();

   crc32_reflected_byte_stream_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   crc32_stream_checker u_crc_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always #2 clock = ~clock;

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   // response side flow control
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_byte(input data_byte_type data, input logic first, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.data_byte  <= data;
      req_bus.first_byte <= first;
      req_bus.last_byte  <= last;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
   endtask

   task automatic send_message(input int len, input bit noisy);
      int   i;
      logic first;
      logic last;
      for (i = 0; i < len; i++) begin
         first = (i == 0);
         last  = (i == len - 1);
         if (noisy) begin
            first = 1'($urandom_range(1));
            last  = 1'($urandom_range(1));
         end
         send_byte(data_byte_type'($urandom_range(255)), first, last);
      end
   endtask

   initial begin : stimulus
      int phase;
      int sent;
      int len;
      int i;
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.data_byte  <= '0;
      req_bus.first_byte <= 1'b0;
      req_bus.last_byte  <= 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      long_hold      = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // starts from the reset remainder, no first mark
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b1);
      // byte after a final byte without first mark keeps the remainder
      send_byte(8'h5A, 1'b0, 1'b0);
      // one-byte messages
      send_byte(8'h01, 1'b1, 1'b1);
      send_byte(8'h80, 1'b1, 1'b1);
      send_byte(8'hFF, 1'b1, 1'b1);
      send_byte(8'h00, 1'b1, 1'b1);
      // ascii check string
      for (i = 0; i < 9; i++) begin
         send_byte(data_byte_type'(8'h31 + i), i == 0, i == 8);
      end
      // restart in the middle of a message
      send_byte(8'hAA, 1'b1, 1'b0);
      send_byte(8'h55, 1'b0, 1'b0);
      send_byte(8'hC3, 1'b1, 1'b0);
      send_byte(8'h3C, 1'b0, 1'b1);

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
               long_hold      = 1'b1;
            end
            1: begin
               send_idle_pct  = 55;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 55;
            end
            default: begin
               send_idle_pct  = 38;
               recv_stall_pct = 38;
            end
         endcase
         sent = 0;
         while (sent < PHASE_BYTES) begin
            if ($urandom_range(99) < 10) begin
               len = $urandom_range(17, 64);
            end else begin
               len = $urandom_range(1, 16);
            end
            send_message(len, $urandom_range(99) < 15);
            sent = sent + len;
         end
      end
      req_bus.valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+design
design/crc32_pkg.sv
design/crc32_req_if.sv
design/crc32_rsp_if.sv
design/crc32_reflected_byte_stream_top.sv
tb/sv/crc32_stream_checker.sv
tb/sv/crc32_reflected_byte_stream_top_tb.sv
